@@ design/assert_macros.svh @@
// Assertion macros shared by the clip list builder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked at every rising edge outside reset.
`define DCLB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define DCLB_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ design/dclb_pkg.sv @@
// Types and constants shared by the clip list builder modules.
package dclb_pkg;

  localparam int OUT_W      = 16;
  localparam int CFG_W      = 16;
  localparam int TOT_W      = 17;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int CFG_ADDR_W = 5;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    KIND_CLIP = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_DAMAGE_LEFT   = 3'd0,
    REG_DAMAGE_TOP    = 3'd1,
    REG_DAMAGE_WIDTH  = 3'd2,
    REG_DAMAGE_HEIGHT = 3'd3,
    REG_LIST_CAPACITY = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] dmg_left;
    logic [CFG_W-1:0] dmg_top;
    logic [CFG_W-1:0] dmg_width;
    logic [CFG_W-1:0] dmg_height;
    logic [CFG_W-1:0] capacity;
  } dclb_cfg_t;

  // One queued item: an optional clip followed by an optional done result.
  typedef struct packed {
    logic             has_clip;
    logic             has_done;
    logic             done_fail;
    logic [OUT_W-1:0] left;
    logic [OUT_W-1:0] top;
    logic [OUT_W-1:0] width;
    logic [OUT_W-1:0] height;
    logic [OUT_W-1:0] clip_index;
    logic [OUT_W-1:0] done_count;
  } dclb_entry_t;

endpackage

@@ design/dclb_front.sv @@
// Front end: intersects each rectangle with the damage area and tracks the list count.
`include "assert_macros.svh"

module dclb_front
  import dclb_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [15:0]       vis_left,
  input  logic [15:0]       vis_top,
  input  logic [15:0]       vis_width,
  input  logic [15:0]       vis_height,
  input  logic              batch_first,
  input  logic              batch_last,
  input  dclb_cfg_t         cfg,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output dclb_entry_t       q_entry
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = COORD_WIDTH + 1;
  localparam int CMPW = (COORD_WIDTH > TOT_W) ? COORD_WIDTH : TOT_W;
  localparam int SW   = QCNT_W + 1;

  logic [CW-1:0] vl, vt, vw, vh, dl, dt, dw, dh, cap;
  logic [CW-1:0] l_a, t_a;
  logic [EW-1:0] vr, vb, dr, db, r_a, b_a;
  logic          accept;

  // stage 1 registers
  logic          s1_valid;
  logic          s1_first, s1_last, s1_nonzero;
  logic [CW-1:0] s1_l, s1_t;
  logic [EW-1:0] s1_r, s1_b;

  // batch state
  logic [TOT_W-1:0] clip_total, clip_total_next;
  logic             batch_failed, batch_failed_next;
  logic [TOT_W-1:0] clip_idx;
  logic             take_clip, dmg_empty;

  // space is reserved for the item already in stage 1
  assign full   = (SW'(q_count) + SW'(s1_valid)) >= SW'(QDEPTH);
  assign accept = push && !full;

  assign vl  = CW'(vis_left);
  assign vt  = CW'(vis_top);
  assign vw  = CW'(vis_width);
  assign vh  = CW'(vis_height);
  assign dl  = CW'(cfg.dmg_left);
  assign dt  = CW'(cfg.dmg_top);
  assign dw  = CW'(cfg.dmg_width);
  assign dh  = CW'(cfg.dmg_height);
  assign cap = CW'(cfg.capacity);

  assign l_a = (vl > dl) ? vl : dl;
  assign t_a = (vt > dt) ? vt : dt;
  assign vr  = EW'(vl) + EW'(vw);
  assign vb  = EW'(vt) + EW'(vh);
  assign dr  = EW'(dl) + EW'(dw);
  assign db  = EW'(dt) + EW'(dh);
  assign r_a = (vr < dr) ? vr : dr;
  assign b_a = (vb < db) ? vb : db;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first   <= batch_first;
      s1_last    <= batch_last;
      s1_nonzero <= (vw != '0) && (vh != '0);
      s1_l       <= l_a;
      s1_t       <= t_a;
      s1_r       <= r_a;
      s1_b       <= b_a;
    end
  end

  assign dmg_empty = (dw == '0) || (dh == '0);

  always_comb begin
    clip_total_next   = s1_first ? '0 : clip_total;
    batch_failed_next = s1_first ? 1'b0 : batch_failed;
    take_clip         = 1'b0;
    clip_idx          = '0;
    if (dmg_empty) begin
      batch_failed_next = 1'b1;
      clip_total_next   = '0;
    end
    if (!batch_failed_next && s1_nonzero && (s1_r > EW'(s1_l)) && (s1_b > EW'(s1_t))) begin
      if (CMPW'(clip_total_next) >= CMPW'(cap)) begin
        // list overflow fails the batch
        batch_failed_next = 1'b1;
        clip_total_next   = '0;
      end else begin
        take_clip       = 1'b1;
        clip_idx        = clip_total_next;
        clip_total_next = clip_total_next + TOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_total   <= '0;
      batch_failed <= 1'b0;
    end else if (s1_valid) begin
      clip_total   <= clip_total_next;
      batch_failed <= batch_failed_next;
    end
  end

  assign q_push = s1_valid && (take_clip || s1_last);

  always_comb begin
    q_entry.has_clip   = take_clip;
    q_entry.has_done   = s1_last;
    q_entry.done_fail  = batch_failed_next;
    q_entry.left       = OUT_W'(s1_l);
    q_entry.top        = OUT_W'(s1_t);
    q_entry.width      = OUT_W'(s1_r - EW'(s1_l));
    q_entry.height     = OUT_W'(s1_b - EW'(s1_t));
    q_entry.clip_index = OUT_W'(clip_idx);
    q_entry.done_count = batch_failed_next ? '0 : OUT_W'(clip_total_next);
  end

  `DCLB_ASSERT(a_fail_clears_total, clk, rst, batch_failed |-> (clip_total == '0),
               "failed batch holds a nonzero count")

endmodule

@@ design/dclb_queue.sv @@
// Short item queue between the front end and the result stage.
`include "assert_macros.svh"

module dclb_queue
  import dclb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  dclb_entry_t       wr_entry,
  input  logic              deq,
  output dclb_entry_t       head,
  output logic              q_empty,
  output logic [QCNT_W-1:0] count
);

  dclb_entry_t       slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign head    = slots[rd_ptr];
  assign q_empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({wr_en, deq})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  `DCLB_NEVER(a_no_overflow, clk, rst, wr_en && (count == QCNT_W'(QDEPTH)),
              "write into a full item queue")
  `DCLB_NEVER(a_no_underflow, clk, rst, deq && (count == '0),
              "dequeue from an empty item queue")

endmodule

@@ design/dclb_back.sv @@
// Result stage: expands queued items into clip and done results behind an output register.
`include "assert_macros.svh"

module dclb_back
  import dclb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dclb_entry_t      head,
  input  logic             q_empty,
  output logic             deq,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       kind,
  output logic [OUT_W-1:0] clip_left,
  output logic [OUT_W-1:0] clip_top,
  output logic [OUT_W-1:0] clip_width,
  output logic [OUT_W-1:0] clip_height,
  output logic [OUT_W-1:0] clip_index,
  output logic             run_last
);

  logic  out_valid;
  logic  done_phase;
  logic  load, emit_done;
  kind_t out_kind;

  assign load      = !q_empty && (!out_valid || pop);
  assign emit_done = done_phase || !head.has_clip;
  assign deq       = load && (emit_done || !head.has_done);
  assign empty     = !out_valid;
  assign kind      = out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      done_phase <= 1'b0;
    end else if (load) begin
      out_valid  <= 1'b1;
      // clip goes out first; the done result of the same item follows
      done_phase <= emit_done ? 1'b0 : head.has_done;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_done) begin
        out_kind    <= head.done_fail ? KIND_FAIL : KIND_OK;
        clip_left   <= '0;
        clip_top    <= '0;
        clip_width  <= '0;
        clip_height <= '0;
        clip_index  <= head.done_count;
        run_last    <= 1'b1;
      end else begin
        out_kind    <= KIND_CLIP;
        clip_left   <= head.left;
        clip_top    <= head.top;
        clip_width  <= head.width;
        clip_height <= head.height;
        clip_index  <= head.clip_index;
        run_last    <= !head.has_done;
      end
    end
  end

  `DCLB_ASSERT(a_done_phase_head, clk, rst,
               done_phase |-> (!q_empty && head.has_clip && head.has_done),
               "done phase without a clip-and-done item at the queue head")

endmodule

@@ design/damage_clip_list_builder.sv @@
// Top level of the damage clip list builder: config registers, front end, queue, result stage.
// Path: stage 1 register, then the item queue, then the result register.
// One item accepted per cycle while full is low; an item that yields both a clip and a done
// result uses the single result register for each in turn, and the 4-entry queue absorbs it.
// Reset (rst, synchronous): empties pipeline, queue and result register, clears the
// list count and failure flag, and sets all configuration registers to 0.
module damage_clip_list_builder
  import dclb_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [15:0]           vis_left,
  input  logic [15:0]           vis_top,
  input  logic [15:0]           vis_width,
  input  logic [15:0]           vis_height,
  input  logic                  batch_first,
  input  logic                  batch_last,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            kind,
  output logic [OUT_W-1:0]      clip_left,
  output logic [OUT_W-1:0]      clip_top,
  output logic [OUT_W-1:0]      clip_width,
  output logic [OUT_W-1:0]      clip_height,
  output logic [OUT_W-1:0]      clip_index,
  output logic                  run_last
);

  dclb_cfg_t         cfg;
  reg_index_t        reg_sel;
  logic              cfg_wr;
  logic              q_push, q_deq, q_empty;
  logic [QCNT_W-1:0] q_count;
  dclb_entry_t       q_wr_entry, q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DAMAGE_LEFT:   cfg.dmg_left   <= pwdata[CFG_W-1:0];
        REG_DAMAGE_TOP:    cfg.dmg_top    <= pwdata[CFG_W-1:0];
        REG_DAMAGE_WIDTH:  cfg.dmg_width  <= pwdata[CFG_W-1:0];
        REG_DAMAGE_HEIGHT: cfg.dmg_height <= pwdata[CFG_W-1:0];
        REG_LIST_CAPACITY: cfg.capacity   <= pwdata[CFG_W-1:0];
        default:           cfg            <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DAMAGE_LEFT:   prdata = PDATA_W'(cfg.dmg_left);
      REG_DAMAGE_TOP:    prdata = PDATA_W'(cfg.dmg_top);
      REG_DAMAGE_WIDTH:  prdata = PDATA_W'(cfg.dmg_width);
      REG_DAMAGE_HEIGHT: prdata = PDATA_W'(cfg.dmg_height);
      REG_LIST_CAPACITY: prdata = PDATA_W'(cfg.capacity);
      default:           prdata = '0;
    endcase
  end

  dclb_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .vis_left   (vis_left),
    .vis_top    (vis_top),
    .vis_width  (vis_width),
    .vis_height (vis_height),
    .batch_first(batch_first),
    .batch_last (batch_last),
    .cfg        (cfg),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_entry    (q_wr_entry)
  );

  dclb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_entry(q_wr_entry),
    .deq     (q_deq),
    .head    (q_head),
    .q_empty (q_empty),
    .count   (q_count)
  );

  dclb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .deq        (q_deq),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .clip_left  (clip_left),
    .clip_top   (clip_top),
    .clip_width (clip_width),
    .clip_height(clip_height),
    .clip_index (clip_index),
    .run_last   (run_last)
  );

endmodule
